// ===== rtl/dgma_pkg.sv =====
// ---------------------------------------------------------------------------
// dgma_pkg: shared types and constants
// payload structs, status and mode codes, controller states and commands
// ---------------------------------------------------------------------------
package dgma_pkg;

  localparam int unsigned DistW = 16;
  localparam int unsigned FiltW = 20;

  typedef enum logic [1:0] {
    MODE_SAMPLE = 2'd0,
    MODE_FAULT  = 2'd1,
    MODE_CLEAR  = 2'd2,
    MODE_NONE   = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    ST_ACCEPTED = 3'd0,
    ST_RANGE    = 3'd1,
    ST_JUMP     = 3'd2,
    ST_FAULT    = 3'd3,
    ST_CLEARED  = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    CFG_OFFSET  = 3'd0,
    CFG_MIN     = 3'd1,
    CFG_MAX     = 3'd2,
    CFG_JUMP    = 3'd3,
    CFG_MED_ON  = 3'd4,
    CFG_MED_LEN = 3'd5,
    CFG_AVG_LEN = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic [1:0]       mode;
    logic [DistW-1:0] raw_mm;
  } in_item_t;

  typedef struct packed {
    logic [2:0]       status;
    logic [DistW-1:0] corrected_mm;
    logic [DistW-1:0] median_mm;
    logic [FiltW-1:0] filtered_q4;
    logic             filtered_ok;
  } out_item_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CLEAR,
    S_GATE,
    S_MWR,
    S_MSORT,
    S_AWR,
    S_ASUM,
    S_DIV,
    S_DONE
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic load;       // latch input item
    logic clr_step;   // one step of clear sweep
    logic clr_start;
    logic gate;       // evaluate gate, status
    logic med_write;
    logic sort_step;
    logic avg_write;
    logic sum_step;
    logic div_start;
    logic div_step;
    logic commit;     // update filtered state
    logic fault;
    logic set_status; // status from mode codes
    logic emit;       // copy result fields to the output register
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_sample;
    logic is_clear;
    logic pass;       // gate accepted
    logic med_en;
    logic avg_en;
    logic clr_done;
    logic sort_done;
    logic sum_done;
    logic div_done;
  } sts_t;

endpackage

// ===== rtl/dgma_ctrl.sv =====
// ---------------------------------------------------------------------------
// dgma_ctrl: sequencing state machine
// steps one item through gate or clear sweep, median sort, average sum and divide
// ---------------------------------------------------------------------------
module dgma_ctrl import dgma_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  output logic out_valid_o,
  input  logic out_stall_i,
  output cmd_t cmd_o,
  input  sts_t sts_i
);

  state_e state_q, state_d;
  logic   ovalid_q, ovalid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      ovalid_q <= ovalid_d;
    end
  end

  assign out_valid_o = ovalid_q;
  assign in_stall_o  = (state_q != S_IDLE);

  always_comb begin
    state_d  = state_q;
    ovalid_d = ovalid_q && out_stall_i;
    cmd_o    = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_GATE;
        end
      end
      S_GATE: begin
        if (sts_i.is_sample) begin
          cmd_o.gate = 1'b1;
          if (!sts_i.pass) begin
            state_d = S_DONE;
          end else if (sts_i.med_en) begin
            state_d = S_MWR;
          end else begin
            state_d = S_AWR;
          end
        end else if (sts_i.is_clear) begin
          cmd_o.set_status = 1'b1;
          cmd_o.clr_start  = 1'b1;
          state_d          = S_CLEAR;
        end else begin
          cmd_o.set_status = 1'b1;
          cmd_o.fault      = 1'b1;
          state_d          = S_DONE;
        end
      end
      S_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_done) begin
          state_d = S_DONE;
        end
      end
      S_MWR: begin
        cmd_o.med_write = 1'b1;
        state_d         = S_MSORT;
      end
      S_MSORT: begin
        cmd_o.sort_step = 1'b1;
        if (sts_i.sort_done) begin
          state_d = S_AWR;
        end
      end
      S_AWR: begin
        cmd_o.avg_write = 1'b1;
        state_d         = sts_i.avg_en ? S_ASUM : S_DONE;
        cmd_o.commit    = !sts_i.avg_en;
      end
      S_ASUM: begin
        cmd_o.sum_step = 1'b1;
        if (sts_i.sum_done) begin
          cmd_o.div_start = 1'b1;
          state_d         = S_DIV;
        end
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_done) begin
          cmd_o.commit = 1'b1;
          state_d      = S_DONE;
        end
      end
      S_DONE: begin
        if (!ovalid_q || !out_stall_i) begin
          cmd_o.emit = 1'b1;
          ovalid_d   = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

// ===== rtl/dgma_datapath.sv =====
// ---------------------------------------------------------------------------
// dgma_datapath: gate, median ring and rank sort, average ring, divider
// median by rank counting one entry per cycle, sum one entry per cycle,
// restoring divide one quotient bit per cycle
// ---------------------------------------------------------------------------
module dgma_datapath import dgma_pkg::*; #(
  parameter int unsigned MedianDepth  = 15,
  parameter int unsigned AverageDepth = 32
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [2:0]      cfg_idx_i,
  input  logic [15:0]     cfg_data_i,
  input  in_item_t        in_data_i,
  output out_item_t       out_data_o,
  input  cmd_t            cmd_i,
  output sts_t            sts_o
);

  localparam int unsigned MW  = $clog2(MedianDepth);
  localparam int unsigned MCW = $clog2(MedianDepth + 1);
  localparam int unsigned AW  = (AverageDepth > 1) ? $clog2(AverageDepth) : 1;
  localparam int unsigned ACW = $clog2(AverageDepth + 1);
  localparam int unsigned SW  = DistW + ACW;     // sum width
  localparam int unsigned NW  = SW + 4;          // dividend width
  localparam int unsigned CW  = (MW > AW ? MW : AW) + 1;
  localparam int unsigned MaxDepth = (MedianDepth > AverageDepth) ? MedianDepth
                                                                  : AverageDepth;

  // configuration
  logic [15:0] offset_q, min_q, max_q, jump_q;
  logic        med_on_q;
  logic [7:0]  med_len_q, avg_len_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q  <= '0;
      min_q     <= '0;
      max_q     <= 16'hFFFF;
      jump_q    <= 16'hFFFF;
      med_on_q  <= 1'b1;
      med_len_q <= 8'd5;
      avg_len_q <= 8'd8;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_OFFSET:  offset_q  <= cfg_data_i;
        CFG_MIN:     min_q     <= cfg_data_i;
        CFG_MAX:     max_q     <= cfg_data_i;
        CFG_JUMP:    jump_q    <= cfg_data_i;
        CFG_MED_ON:  med_on_q  <= cfg_data_i[0];
        CFG_MED_LEN: med_len_q <= cfg_data_i[7:0];
        CFG_AVG_LEN: avg_len_q <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // effective windows
  logic [MCW-1:0] mwin;
  logic [ACW-1:0] awin;
  always_comb begin
    if (32'(med_len_q) > MedianDepth) mwin = MCW'(MedianDepth);
    else                              mwin = MCW'(med_len_q);
    if (32'(avg_len_q) > AverageDepth) awin = ACW'(AverageDepth);
    else                               awin = ACW'(avg_len_q);
  end
  assign sts_o.med_en = med_on_q && (med_len_q >= 8'd3);
  assign sts_o.avg_en = (avg_len_q != 8'd0);

  // item
  logic [1:0]  mode_q;
  logic [15:0] raw_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mode_q <= in_data_i.mode;
      raw_q  <= in_data_i.raw_mm;
    end
  end
  assign sts_o.is_sample = (mode_e'(mode_q) == MODE_SAMPLE);
  assign sts_o.is_clear  = (mode_e'(mode_q) == MODE_CLEAR);

  // state
  logic [MW-1:0]  mpos_q;
  logic [MCW-1:0] mfill_q;
  logic [AW-1:0]  apos_q;
  logic [ACW-1:0] afill_q;
  logic [FiltW-1:0] last_q;
  logic           have_q, meas_q;

  // correction and gate
  logic signed [17:0] sum18;
  logic [15:0] corr;
  logic [FiltW:0] c16, l16, step;
  logic in_rng, pass;
  always_comb begin
    sum18 = $signed({2'b00, raw_q}) + $signed({{2{offset_q[15]}}, offset_q});
    if (sum18 < 0)                 corr = '0;
    else if (sum18 > 18'sd65535)   corr = 16'hFFFF;
    else                           corr = sum18[15:0];
    in_rng = (corr >= min_q) && (corr <= max_q);
    c16  = {1'b0, corr, 4'h0};
    l16  = {1'b0, last_q};
    step = (c16 > l16) ? c16 - l16 : l16 - c16;
    pass = in_rng && !(meas_q && have_q && (step > {1'b0, jump_q, 4'h0}));
  end
  assign sts_o.pass = pass;

  // result registers
  logic [2:0]  status_q;
  logic [15:0] corr_q, med_q;
  logic [FiltW-1:0] fout_q;
  logic        fok_q;
  out_item_t   out_q;

  // rings
  logic [15:0] mring_q [MedianDepth];
  logic [15:0] aring_q [AverageDepth];
  logic [MW-1:0] mwpos;
  logic [AW-1:0] awpos;
  always_comb begin
    mwpos = (MCW'(mpos_q) >= mwin) ? '0 : mpos_q;
    awpos = (ACW'(apos_q) >= awin) ? '0 : apos_q;
  end

  // shared counters for sort and sum / clear
  logic [CW-1:0] i_q, j_q;
  logic [MCW-1:0] less_q, leq_q;
  logic [SW-1:0] sum_q;
  logic [MCW-1:0] half;
  assign half = mfill_q >> 1;

  // median by rank: candidate i is median if less(i) <= half < leq(i)
  logic [15:0] cand, other;
  logic found_q;
  logic found_now;
  logic [MCW-1:0] less_n, leq_n;
  assign cand  = mring_q[i_q[MW-1:0]];
  assign other = mring_q[j_q[MW-1:0]];
  assign sts_o.sort_done = (MCW'(j_q) == mfill_q - 1'b1) &&
                           ((MCW'(i_q) == mfill_q - 1'b1) || found_now);
  always_comb begin
    less_n = less_q + MCW'(other < cand);
    leq_n  = leq_q + MCW'(other <= cand);
    found_now = (MCW'(j_q) == mfill_q - 1'b1) && (less_n <= half) && (half < leq_n);
  end

  assign sts_o.sum_done = (ACW'(j_q) == afill_q - 1'b1);
  assign sts_o.clr_done = (32'(j_q) == MaxDepth - 1);

  // divider
  logic [NW-1:0] quo_q;
  logic [ACW:0]  rem_q;
  logic [$clog2(NW+1)-1:0] dcnt_q;
  logic [ACW:0] rsh;
  logic [NW-1:0] quo_n;
  assign sts_o.div_done = (32'(dcnt_q) == NW - 1);
  always_comb rsh = {rem_q[ACW-1:0], quo_q[NW-1]};
  assign quo_n = {quo_q[NW-2:0], (rsh >= {1'b0, afill_q})};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mpos_q <= '0; mfill_q <= '0; apos_q <= '0; afill_q <= '0;
      last_q <= '0; have_q <= 1'b0; meas_q <= 1'b0;
    end else begin
      if (cmd_i.clr_start) begin
        mpos_q <= '0; mfill_q <= '0; apos_q <= '0; afill_q <= '0;
        last_q <= '0; have_q <= 1'b0;
      end
      if (cmd_i.fault && (mode_e'(mode_q) == MODE_FAULT)) meas_q <= 1'b0;
      if (cmd_i.med_write) begin
        mpos_q  <= (MCW'(mwpos) + 1'b1 >= mwin) ? '0 : MW'(mwpos + 1'b1);
        if (mfill_q < mwin) mfill_q <= mfill_q + 1'b1;
        else                mfill_q <= mwin;
      end
      if (cmd_i.avg_write && sts_o.avg_en) begin
        apos_q  <= (ACW'(awpos) + 1'b1 >= awin) ? '0 : AW'(awpos + 1'b1);
        if (afill_q < awin) afill_q <= afill_q + 1'b1;
        else                afill_q <= awin;
      end
      if (cmd_i.commit) begin
        have_q <= 1'b1;
        meas_q <= 1'b1;
        last_q <= sts_o.avg_en ? quo_n[FiltW-1:0] : {med_q, 4'h0};
      end
    end
  end

  // ring contents, zero after reset and after a clear sweep
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < MedianDepth; k++) mring_q[k] <= '0;
      for (int k = 0; k < AverageDepth; k++) aring_q[k] <= '0;
    end else begin
      if (cmd_i.clr_step) begin
        if (32'(j_q) < MedianDepth)  mring_q[j_q[MW-1:0]] <= '0;
        if (32'(j_q) < AverageDepth) aring_q[j_q[AW-1:0]] <= '0;
      end
      if (cmd_i.med_write) mring_q[mwpos] <= corr_q;
      if (cmd_i.avg_write && sts_o.avg_en) aring_q[awpos] <= med_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_start) begin
      j_q <= '0;
    end
    if (cmd_i.clr_step) begin
      j_q <= j_q + 1'b1;
    end
    if (cmd_i.med_write) begin
      i_q <= '0; j_q <= '0; less_q <= '0; leq_q <= '0; found_q <= 1'b0;
    end
    if (cmd_i.sort_step) begin
      if (MCW'(j_q) == mfill_q - 1'b1) begin
        if (!found_q && found_now) begin
          med_q <= cand; found_q <= 1'b1;
        end
        i_q <= i_q + 1'b1; j_q <= '0; less_q <= '0; leq_q <= '0;
      end else begin
        j_q <= j_q + 1'b1; less_q <= less_n; leq_q <= leq_n;
      end
    end
    if (cmd_i.avg_write) begin
      j_q <= '0; sum_q <= '0;
      if (!sts_o.avg_en) fout_q <= {med_q, 4'h0};
    end
    if (cmd_i.sum_step) begin
      sum_q <= sum_q + SW'(aring_q[j_q[AW-1:0]]);
      j_q   <= j_q + 1'b1;
    end
    if (cmd_i.div_start) begin
      quo_q  <= {sum_q + SW'(aring_q[j_q[AW-1:0]]), 4'h0};
      rem_q  <= '0;
      dcnt_q <= '0;
    end
    if (cmd_i.div_step) begin
      if (rsh >= {1'b0, afill_q}) begin
        rem_q <= rsh - {1'b0, afill_q};
      end else begin
        rem_q <= rsh;
      end
      quo_q  <= quo_n;
      dcnt_q <= dcnt_q + 1'b1;
      if (sts_o.div_done) begin
        fout_q <= quo_n[FiltW-1:0];
      end
    end
    // result fields
    if (cmd_i.gate) begin
      corr_q   <= corr;
      med_q    <= pass ? corr : '0;
      status_q <= !in_rng ? ST_RANGE : (pass ? ST_ACCEPTED : ST_JUMP);
      fout_q   <= last_q;
      fok_q    <= have_q;
    end
    if (cmd_i.set_status) begin
      corr_q <= '0;
      med_q  <= '0;
      fout_q <= sts_o.is_clear ? '0 : last_q;
      fok_q  <= sts_o.is_clear ? 1'b0 : have_q;
      unique case (mode_e'(mode_q))
        MODE_FAULT: status_q <= ST_FAULT;
        MODE_CLEAR: status_q <= ST_CLEARED;
        default:    status_q <= ST_RANGE;
      endcase
    end
    if (cmd_i.commit) fok_q <= 1'b1;
    // output beat holds while the next item is worked on
    if (cmd_i.emit) begin
      out_q.status       <= status_q;
      out_q.corrected_mm <= corr_q;
      out_q.median_mm    <= med_q;
      out_q.filtered_q4  <= fout_q;
      out_q.filtered_ok  <= fok_q;
    end
  end

  assign out_data_o = out_q;

endmodule

// ===== rtl/distance_gate_median_average.sv =====
// ---------------------------------------------------------------------------
// distance_gate_median_average: distance gate with median and average
// offset, range and jump gate, sliding median, moving average in 16.4
// ---------------------------------------------------------------------------
// One item at a time. A rejected sample, a fault or an unused mode goes
// from the gate straight to the output; a clear sweeps both rings over
// the larger of MedianDepth and AverageDepth entries. An accepted sample
// runs the median rank count, one compare per cycle, comparing each
// candidate against every entry of the median fill and ending once the
// median is found (skipped in median bypass); the average sum, one add per
// entry of the average fill; and the restoring divide, one quotient bit
// per cycle over a 20 + clog2(AverageDepth+1) bit dividend, 26 bits with
// the default depth (sum and divide skipped in average bypass). The output
// register lets the block take and work on the next item while a finished
// beat waits.
module distance_gate_median_average import dgma_pkg::*; #(
  parameter int unsigned MedianDepth  = 15,
  parameter int unsigned AverageDepth = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cfg_we_i,
  input  logic [2:0] cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);

  cmd_t cmd;
  sts_t sts;

  dgma_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i,
    .cmd_o(cmd), .sts_i(sts)
  );

  dgma_datapath #(.MedianDepth(MedianDepth), .AverageDepth(AverageDepth)) u_dp (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i, .in_data_i,
    .out_data_o, .cmd_i(cmd), .sts_o(sts)
  );

endmodule
